// ===== hw/rtl/lzwe_pkg.sv =====
// Shared types and constants for the LZW encoder.
package lzwe_pkg;
	localparam int unsigned ROOT_CODES = 256;
	localparam logic [31:0] HASH_MULT = 32'd2654435761;

	typedef struct packed {
		logic take_byte;
		logic load_slot;
		logic probe_next;
		logic set_prefix_byte;
		logic set_prefix_hit;
		logic write_entry;
		logic put_prefix;
		logic put_pad;
		logic pop_byte;
		logic clear_start;
		logic clear_step;
		logic stream_reset;
	} lzwe_cmd_t;

	typedef struct packed {
		logic prefix_valid;
		logic last;
		logic slot_valid;
		logic slot_match;
		logic probe_done;
		logic can_insert;
		logic has_byte;
		logic final_byte;
		logic clear_done;
		logic dict_dirty;
	} lzwe_sts_t;
endpackage

// ===== hw/rtl/lzw_encoder_variable_width_unit.sv =====
// Top level of the LZW encoder.
//
// Channel  Handshake            Fields
// input    in_valid/in_ready    data_byte, end_of_data
// result   out_valid/out_ready  out_byte, out_last
//
// A byte that hits the dictionary passes the accept, hash, read and check steps.
// A miss also passes a drain step that releases the packed code bytes; each extra probe repeats read and check.
// The first byte of a stream is accepted and becomes the prefix; the last adds the final code,
// its bytes and a padding step (pad, then pad out) when a partial byte remains.
// After reset, and after any stream that added entries, a clearing pass over
// all HASH_DEPTH slots holds in_ready low. Output stalls hold the datapath.
module lzw_encoder_variable_width_unit #(
	parameter int unsigned MAX_CODE_BITS = 12,
	parameter int unsigned HASH_DEPTH    = 8192
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       end_of_data,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       out_last
);
	lzwe_pkg::lzwe_cmd_t cmd;
	lzwe_pkg::lzwe_sts_t sts;

	lzwe_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_last(out_last),
		.sts(sts),
		.cmd(cmd)
	);

	lzwe_datapath #(
		.MAX_CODE_BITS(MAX_CODE_BITS),
		.HASH_DEPTH(HASH_DEPTH)
	) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.data_byte(data_byte),
		.end_of_data(end_of_data),
		.byte_out(out_byte)
	);

	property p_out_hold;
		@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last);
	endproperty
	a_out_hold: assert property (p_out_hold);

	a_in_out_apart: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid);

	a_last_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_last |-> out_valid);
endmodule

// ===== hw/rtl/lzwe_datapath.sv =====
// Datapath: hashed dictionary memory, prefix register and bit packer.
module lzwe_datapath #(
	parameter int unsigned MAX_CODE_BITS = 12,
	parameter int unsigned HASH_DEPTH    = 8192
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lzwe_pkg::lzwe_cmd_t cmd,
	output lzwe_pkg::lzwe_sts_t sts,
	input  logic [7:0]          data_byte,
	input  logic                end_of_data,
	output logic [7:0]          byte_out
);
	// HASH_DEPTH must be a power of two (not checked here): the slot index wraps by overflow
	localparam int unsigned HW = $clog2(HASH_DEPTH);
	localparam int unsigned CW = MAX_CODE_BITS;
	localparam int unsigned NW = MAX_CODE_BITS + 1;
	localparam int unsigned AW = CW + 8;
	localparam int unsigned BW = $clog2(AW + 1);
	localparam logic [NW-1:0] ENTRY_LIMIT = NW'((1 << MAX_CODE_BITS) - 1);
	localparam int unsigned EW = 1 + CW + 8 + CW;

	logic [EW-1:0] mem_q [HASH_DEPTH];
	logic [EW-1:0] rd_q;
	logic [HW-1:0] idx_q;
	logic [HW:0]   probe_cnt_q;
	logic [HW:0]   clr_q;
	logic          dirty_q;
	logic [7:0]    byte_q;
	logic          last_q;
	logic [CW-1:0] prefix_q;
	logic          pvalid_q;
	logic [NW-1:0] count_q;
	logic [AW-1:0] acc_q;
	logic [BW-1:0] held_q;

	logic [4:0]    width;
	logic [31:0]   key;
	logic [HW-1:0] slot_start;
	logic          rd_valid;
	logic [CW-1:0] rd_pre;
	logic [7:0]    rd_byte;
	logic [CW-1:0] rd_code;

	assign key        = (32'(prefix_q) << 8) | 32'(byte_q);
	// only the low index bits of the product are kept
	assign slot_start = HW'(key * lzwe_pkg::HASH_MULT);
	assign rd_valid   = rd_q[EW-1];
	assign rd_pre     = rd_q[EW-2 -: CW];
	assign rd_byte    = rd_q[CW+7 -: 8];
	assign rd_code    = rd_q[CW-1:0];

	always_comb begin
		width = 5'd0;
		for (int i = 0; i < NW; i++)
			if (count_q[i]) width = 5'(i + 1);
	end

	always_ff @(posedge clk) begin
		if (cmd.clear_step) mem_q[clr_q[HW-1:0]] <= '0;
		else if (cmd.write_entry)
			mem_q[idx_q] <= {1'b1, prefix_q, byte_q, count_q[CW-1:0]};
		rd_q <= mem_q[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0; probe_cnt_q <= '0; clr_q <= '0; dirty_q <= 1'b0;
			byte_q <= '0; last_q <= 1'b0; prefix_q <= '0; pvalid_q <= 1'b0;
			count_q <= NW'(lzwe_pkg::ROOT_CODES); acc_q <= '0; held_q <= '0;
		end else begin
			if (cmd.take_byte) begin
				byte_q <= data_byte;
				last_q <= end_of_data;
			end
			if (cmd.load_slot) begin
				idx_q <= slot_start;
				probe_cnt_q <= '0;
			end else if (cmd.probe_next) begin
				idx_q <= idx_q + 1'b1;
				probe_cnt_q <= probe_cnt_q + 1'b1;
			end
			if (cmd.clear_start) clr_q <= '0;
			else if (cmd.clear_step) clr_q <= clr_q + 1'b1;
			if (cmd.clear_step) dirty_q <= 1'b0;
			else if (cmd.write_entry) dirty_q <= 1'b1;
			if (cmd.stream_reset) begin
				count_q <= NW'(lzwe_pkg::ROOT_CODES);
				prefix_q <= '0;
				pvalid_q <= 1'b0;
			end else begin
				if (cmd.write_entry) count_q <= count_q + 1'b1;
				if (cmd.set_prefix_byte) begin
					prefix_q <= CW'(byte_q);
					pvalid_q <= 1'b1;
				end else if (cmd.set_prefix_hit) prefix_q <= rd_code;
			end
			// prefix code is always below the entry count, so it fits the width unmasked
			if (cmd.stream_reset) begin
				acc_q <= '0;
				held_q <= '0;
			end else if (cmd.put_prefix) begin
				acc_q <= (acc_q << width) | AW'(prefix_q);
				held_q <= held_q + BW'(width);
			end else if (cmd.pop_byte) begin
				held_q <= held_q - BW'(8);
			end else if (cmd.put_pad) begin
				acc_q <= acc_q << (BW'(8) - held_q);
				held_q <= BW'(8);
			end
		end
	end

	assign byte_out = 8'(acc_q >> (held_q - BW'(8)));

	always_comb begin
		sts.prefix_valid = pvalid_q;
		sts.last         = last_q;
		sts.slot_valid   = rd_valid;
		sts.slot_match   = rd_valid && rd_pre == prefix_q && rd_byte == byte_q;
		sts.probe_done   = probe_cnt_q == (HW+1)'(HASH_DEPTH - 1);
		sts.can_insert   = count_q < ENTRY_LIMIT;
		sts.has_byte     = held_q >= BW'(8);
		sts.final_byte   = held_q == BW'(8);
		sts.clear_done   = clr_q == (HW+1)'(HASH_DEPTH - 1);
		sts.dict_dirty   = dirty_q;
	end
endmodule

// ===== hw/rtl/lzwe_ctrl.sv =====
// Controller: sequences lookup, insert, code output and dictionary clearing.
module lzwe_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                out_last,
	input  lzwe_pkg::lzwe_sts_t sts,
	output lzwe_pkg::lzwe_cmd_t cmd
);
	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_FIRST, S_HASH, S_READ, S_CHECK,
		S_DRAIN, S_FINAL, S_FDRAIN, S_PAD, S_PADOUT
	} state_t;
	state_t state_q;
	logic   end_xfer;

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = ((state_q == S_DRAIN || state_q == S_FDRAIN) && sts.has_byte)
		|| state_q == S_PADOUT;
	assign out_last  = (state_q == S_PADOUT) || (state_q == S_FDRAIN && sts.final_byte);
	// transfer of the last byte of a stream
	assign end_xfer  = out_last && out_ready;

	always_comb begin
		cmd = '0;
		case (state_q)
			S_CLEAR: cmd.clear_step = 1'b1;
			S_IDLE:  cmd.take_byte = in_valid;
			S_FIRST: cmd.set_prefix_byte = 1'b1;
			S_HASH:  cmd.load_slot = 1'b1;
			S_CHECK: begin
				if (sts.slot_match) cmd.set_prefix_hit = 1'b1;
				else if (!sts.slot_valid || sts.probe_done) begin
					cmd.put_prefix = 1'b1;
					cmd.set_prefix_byte = 1'b1;
					cmd.write_entry = !sts.slot_valid && sts.can_insert;
				end else cmd.probe_next = 1'b1;
			end
			S_DRAIN: cmd.pop_byte = sts.has_byte && out_ready;
			S_FINAL: cmd.put_prefix = 1'b1;
			S_FDRAIN: begin
				if (sts.final_byte) begin
					cmd.stream_reset = out_ready;
					cmd.clear_start = out_ready;
				end else cmd.pop_byte = sts.has_byte && out_ready;
			end
			S_PAD: cmd.put_pad = 1'b1;
			S_PADOUT: begin
				cmd.stream_reset = out_ready;
				cmd.clear_start = out_ready;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			case (state_q)
				S_CLEAR: if (sts.clear_done) state_q <= S_IDLE;
				S_IDLE: if (in_valid) state_q <= sts.prefix_valid ? S_HASH : S_FIRST;
				S_FIRST: state_q <= sts.last ? S_FINAL : S_IDLE;
				S_HASH: state_q <= S_READ;
				S_READ: state_q <= S_CHECK;
				S_CHECK: begin
					if (sts.slot_match) state_q <= sts.last ? S_FINAL : S_IDLE;
					else if (!sts.slot_valid || sts.probe_done) state_q <= S_DRAIN;
					else state_q <= S_READ;
				end
				S_DRAIN: if (!sts.has_byte) state_q <= sts.last ? S_FINAL : S_IDLE;
				S_FINAL: state_q <= S_FDRAIN;
				S_FDRAIN: begin
					if (end_xfer) state_q <= sts.dict_dirty ? S_CLEAR : S_IDLE;
					else if (!sts.has_byte) state_q <= S_PAD;
				end
				S_PAD: state_q <= S_PADOUT;
				S_PADOUT: if (end_xfer) state_q <= sts.dict_dirty ? S_CLEAR : S_IDLE;
				default: state_q <= S_CLEAR;
			endcase
		end
	end
endmodule
